@@ design/mtod_pkg.sv @@
// ----------------------------------------------------------------------------
// mtod_pkg: shared types and constants for the monotonic time-of-day reader
// Register indexes, opcodes, configuration record, queue entry layout and the
// constants of the divide-by-one-million pipeline.
// ----------------------------------------------------------------------------
package mtod_pkg;

  localparam int LOST_TICK_BITS_DEF = 16;

  localparam int SEC_W  = 32;
  localparam int USEC_W = 20;
  localparam int DIFF_W = 31;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TSC_SHIFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TSC_STAMP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FRAC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_INT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USEC_PER_TICK = 3'd4;

  localparam logic [USEC_W-1:0] USEC_PER_TICK_RST = 20'd10000;

  localparam int FIFO_DEPTH = 2;

  // one million = 2^6 * 15625, quotient taken one 18-bit digit a step
  localparam int USEC_PER_SEC = 1000000;
  localparam int DIV_SHIFT    = 6;
  localparam int DIGIT_BITS   = 18;
  localparam int REM_BITS     = 14;
  localparam logic [REM_BITS-1:0] DIV_BASE = REM_BITS'(USEC_PER_SEC >> DIV_SHIFT);
  localparam int RECIP_SHIFT  = 45;
  localparam logic [31:0] DIV_RECIP = 32'((64'd1 << RECIP_SHIFT) / DIV_BASE);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [4:0]        tsc_shift;
    logic [31:0]       tsc_stamp;
    logic [31:0]       scale_frac;
    logic [31:0]       scale_int;
    logic [USEC_W-1:0] usec_per_tick;
  } cfg_regs_t;

  typedef struct packed {
    opcode_t           op;
    logic [DIFF_W-1:0] diff;
    logic [SEC_W-1:0]  base_sec;
    logic [USEC_W-1:0] base_usec;
  } entry_hdr_t;

  localparam int HDR_W = $bits(entry_hdr_t);

endpackage

@@ design/monotonic_tsc_time_of_day.sv @@
// ----------------------------------------------------------------------------
// monotonic_tsc_time_of_day: monotonic time of day from a scaled cycle counter
// Holds the configuration registers and joins front, queue and back pipeline.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   in        in_valid / in_stall  opcode, counter_now, pend_ticks, base_sec,
//                                  base_usec
//   out       out_valid/ out_stall sec, usec, held_back
//   cfg       cfg_we               cfg_index, cfg_wdata
//
// One beat per cycle sustained on both sides while out_stall is low; a beat
// passes the queue, the multiply stages and the digit pairs of the divide by
// one million on its way from input to result. Reset is synchronous; it clears
// the queue, the floor and the registers, but usec_per_tick resets to 10000.
// A stalled result holds the whole back pipeline; the two-entry queue keeps
// in_stall low until it fills.
// ----------------------------------------------------------------------------
module monotonic_tsc_time_of_day import mtod_pkg::*; #(
  parameter int LOST_TICK_BITS = LOST_TICK_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [63:0]               in_counter_now,
  input  logic [LOST_TICK_BITS-1:0] in_pend_ticks,
  input  logic [SEC_W-1:0]          in_base_sec,
  input  logic [USEC_W-1:0]         in_base_usec,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SEC_W-1:0]          out_sec,
  output logic [USEC_W-1:0]         out_usec,
  output logic                      out_held_back,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int QW = HDR_W + LOST_TICK_BITS;

  cfg_regs_t cfg_r, cfg_nxt;

  logic                      q_push, q_pop, q_full, q_empty;
  entry_hdr_t                f_hdr, b_hdr;
  logic [LOST_TICK_BITS-1:0] f_lost, b_lost;
  logic [QW-1:0]             q_wdata, q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TSC_SHIFT:     cfg_nxt.tsc_shift     = cfg_wdata[4:0];
        CFG_TSC_STAMP:     cfg_nxt.tsc_stamp     = cfg_wdata;
        CFG_SCALE_FRAC:    cfg_nxt.scale_frac    = cfg_wdata;
        CFG_SCALE_INT:     cfg_nxt.scale_int     = cfg_wdata;
        CFG_USEC_PER_TICK: cfg_nxt.usec_per_tick = cfg_wdata[USEC_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tsc_shift     <= '0;
      cfg_r.tsc_stamp     <= '0;
      cfg_r.scale_frac    <= '0;
      cfg_r.scale_int     <= '0;
      cfg_r.usec_per_tick <= USEC_PER_TICK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mtod_front #(
    .LOST_TICK_BITS (LOST_TICK_BITS)
  ) u_front (
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_counter_now (in_counter_now),
    .in_pend_ticks  (in_pend_ticks),
    .in_base_sec    (in_base_sec),
    .in_base_usec   (in_base_usec),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_hdr          (f_hdr),
    .q_lost         (f_lost)
  );

  assign q_wdata = {f_hdr, f_lost};

  mtod_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  assign b_hdr  = entry_hdr_t'(q_rdata[QW-1:LOST_TICK_BITS]);
  assign b_lost = q_rdata[LOST_TICK_BITS-1:0];

  mtod_back #(
    .LOST_TICK_BITS (LOST_TICK_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (!q_empty),
    .q_hdr         (b_hdr),
    .q_lost        (b_lost),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sec       (out_sec),
    .out_usec      (out_usec),
    .out_held_back (out_held_back)
  );

endmodule

@@ design/mtod_front.sv @@
// ----------------------------------------------------------------------------
// mtod_front: input side
// Takes an input beat when the queue has room, shifts the cycle counter,
// forms the clamped counter difference and tags the beat as read or clear.
// ----------------------------------------------------------------------------
module mtod_front import mtod_pkg::*; #(
  parameter int LOST_TICK_BITS = LOST_TICK_BITS_DEF
) (
  input  cfg_regs_t                 cfg,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [63:0]               in_counter_now,
  input  logic [LOST_TICK_BITS-1:0] in_pend_ticks,
  input  logic [SEC_W-1:0]          in_base_sec,
  input  logic [USEC_W-1:0]         in_base_usec,
  input  logic                      q_full,
  output logic                      q_push,
  output entry_hdr_t                q_hdr,
  output logic [LOST_TICK_BITS-1:0] q_lost
);

  logic [63:0] shifted;
  logic [31:0] delta;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign shifted = in_counter_now >> cfg.tsc_shift;
  assign delta   = shifted[31:0] - cfg.tsc_stamp;

  always_comb begin
    q_hdr.op        = opcode_t'(in_opcode);
    // negative difference counts as zero
    q_hdr.diff      = delta[31] ? '0 : delta[DIFF_W-1:0];
    q_hdr.base_sec  = in_base_sec;
    q_hdr.base_usec = in_base_usec;
  end

  assign q_lost = in_pend_ticks;

endmodule

@@ design/mtod_fifo.sv @@
// ----------------------------------------------------------------------------
// mtod_fifo: short queue between front and back
// Register-based queue; lets the front keep taking beats while the back
// pipeline is held by the result side.
// ----------------------------------------------------------------------------
module mtod_fifo import mtod_pkg::*; #(
  parameter int WIDTH = HDR_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign rdata = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ design/mtod_back.sv @@
// ----------------------------------------------------------------------------
// mtod_back: arithmetic pipeline and monotonic floor
// Scales the counter difference, adds tick and base microseconds, divides by
// one million one digit per stage pair, then applies the floor, or for a clear
// zeroes the result and the floor seconds, and registers the result beat.
// ----------------------------------------------------------------------------
module mtod_back import mtod_pkg::*; #(
  parameter int LOST_TICK_BITS = LOST_TICK_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_regs_t                 cfg,
  input  logic                      q_valid,
  input  entry_hdr_t                q_hdr,
  input  logic [LOST_TICK_BITS-1:0] q_lost,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SEC_W-1:0]          out_sec,
  output logic [USEC_W-1:0]         out_usec,
  output logic                      out_held_back
);

  localparam int TICK_W = LOST_TICK_BITS + USEC_W;
  localparam int SUM_W  = ((TICK_W > SEC_W) ? TICK_W : SEC_W) + 2;
  localparam int QUO_W  = SUM_W - DIV_SHIFT;
  localparam int NDIG   = (QUO_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PAD_W  = NDIG * DIGIT_BITS;
  localparam int X_W    = REM_BITS + DIGIT_BITS;

  typedef struct packed {
    opcode_t              op;
    logic [SEC_W-1:0]     base_sec;
    logic [DIV_SHIFT-1:0] lo;
    logic [PAD_W-1:0]     t;
    logic [PAD_W-1:0]     q;
    logic [REM_BITS-1:0]  r;
  } drec_t;

  logic en;

  logic                      v1_r, v2_r, v3_r, v4_r;
  entry_hdr_t                h1_r, h2_r, h3_r;
  logic [LOST_TICK_BITS-1:0] lost1_r, lost2_r;
  logic [DIFF_W-1:0]         pf1_r;
  logic [31:0]               acc2_r, acc3_r;
  logic [TICK_W-1:0]         tick3_r;
  drec_t                     rec4_r;

  logic [62:0]      frac_prod;
  logic [31:0]      int_lo;
  logic [TICK_W-1:0] tick_prod;
  logic [SUM_W-1:0] usec_sum;
  drec_t            rec4_nxt;

  drec_t drec [NDIG+1];
  logic  dval [NDIG+1];

  logic              out_valid_r;
  logic [SEC_W-1:0]  out_sec_r, floor_sec_r;
  logic [USEC_W-1:0] out_usec_r, floor_usec_r;
  logic              held_r;

  drec_t             last;
  logic [SEC_W-1:0]  sec_calc;
  logic [USEC_W-1:0] usec_calc;
  logic              hold;

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_valid;

  // scaled delta: fraction product, then integer product and add
  assign frac_prod = {32'd0, q_hdr.diff} * {31'd0, cfg.scale_frac};
  assign int_lo    = {1'b0, h1_r.diff} * cfg.scale_int;
  assign tick_prod = TICK_W'(lost2_r) * TICK_W'(cfg.usec_per_tick);
  assign usec_sum  = SUM_W'(acc3_r) + SUM_W'(tick3_r) + SUM_W'(h3_r.base_usec);

  always_comb begin
    rec4_nxt.op       = h3_r.op;
    rec4_nxt.base_sec = h3_r.base_sec;
    rec4_nxt.lo       = usec_sum[DIV_SHIFT-1:0];
    rec4_nxt.t        = PAD_W'(usec_sum[SUM_W-1:DIV_SHIFT]);
    rec4_nxt.q        = '0;
    rec4_nxt.r        = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r    <= q_hdr;
      lost1_r <= q_lost;
      pf1_r   <= frac_prod[62:32];
      h2_r    <= h1_r;
      lost2_r <= lost1_r;
      acc2_r  <= 32'(pf1_r) + int_lo;
      h3_r    <= h2_r;
      acc3_r  <= acc2_r;
      tick3_r <= tick_prod;
      rec4_r  <= rec4_nxt;
    end
  end

  assign drec[0] = rec4_r;
  assign dval[0] = v4_r;

  for (genvar j = 0; j < NDIG; j++) begin : g_dig
    logic [X_W-1:0]        x;
    logic [2*X_W-1:0]      prod;
    logic [X_W-1:0]        rem0, rem1;
    logic [DIGIT_BITS-1:0] qd;
    drec_t                 nrec;
    logic                  a_v_r, b_v_r;
    drec_t                 a_rec_r, b_rec_r;
    logic [X_W-1:0]        a_x_r;
    logic [DIGIT_BITS-1:0] a_q_r;

    assign x    = {drec[j].r, drec[j].t[PAD_W-1 -: DIGIT_BITS]};
    assign prod = (2*X_W)'(x) * (2*X_W)'(DIV_RECIP);
    assign rem0 = a_x_r - X_W'(a_q_r) * X_W'(DIV_BASE);

    // estimate is low by at most one
    always_comb begin
      if (rem0 >= X_W'(DIV_BASE)) begin
        rem1 = rem0 - X_W'(DIV_BASE);
        qd   = a_q_r + 1'b1;
      end else begin
        rem1 = rem0;
        qd   = a_q_r;
      end
      nrec   = a_rec_r;
      nrec.r = rem1[REM_BITS-1:0];
      nrec.t = a_rec_r.t << DIGIT_BITS;
      nrec.q = {a_rec_r.q[PAD_W-DIGIT_BITS-1:0], qd};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v_r <= 1'b0;
        b_v_r <= 1'b0;
      end else if (en) begin
        a_v_r <= dval[j];
        b_v_r <= a_v_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_rec_r <= drec[j];
        a_x_r   <= x;
        a_q_r   <= prod[RECIP_SHIFT +: DIGIT_BITS];
        b_rec_r <= nrec;
      end
    end

    assign drec[j+1] = b_rec_r;
    assign dval[j+1] = b_v_r;
  end

  assign last      = drec[NDIG];
  assign sec_calc  = last.base_sec + last.q[SEC_W-1:0];
  assign usec_calc = {last.r, last.lo};
  assign hold      = (sec_calc < floor_sec_r) ||
                     ((sec_calc == floor_sec_r) && (usec_calc < floor_usec_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      floor_sec_r  <= '0;
      floor_usec_r <= '0;
    end else if (en) begin
      out_valid_r <= dval[NDIG];
      if (dval[NDIG]) begin
        if (last.op == OP_CLEAR) begin
          floor_sec_r <= '0;
        end else if (!hold) begin
          floor_sec_r  <= sec_calc;
          floor_usec_r <= usec_calc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (last.op == OP_CLEAR) begin
        out_sec_r  <= '0;
        out_usec_r <= '0;
        held_r     <= 1'b0;
      end else if (hold) begin
        out_sec_r  <= floor_sec_r;
        out_usec_r <= floor_usec_r;
        held_r     <= 1'b1;
      end else begin
        out_sec_r  <= sec_calc;
        out_usec_r <= usec_calc;
        held_r     <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sec       = out_sec_r;
  assign out_usec      = out_usec_r;
  assign out_held_back = held_r;

endmodule
